// ===== rtl/core/bcsg_pkg.sv =====
package bcsg_pkg;

  // Limits and fixed point
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MAX_SENSORS = 16;

  // Field widths
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned GREY_W  = 8;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned ROW_W   = 12;

  // Register widths
  localparam int unsigned NS_W    = 5;
  localparam int unsigned PW_W    = 11;
  localparam int unsigned SP_W    = 11;
  localparam int unsigned CANV_W  = 13;
  localparam int unsigned OFF_W   = 12;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Datapath widths
  localparam int unsigned XPOS_W  = 13;                    // column + offset
  localparam int unsigned KMAG_W  = IDX_W + 1;             // |2(s-t)+-1|
  localparam int unsigned BMUL_W  = IDX_W + 2;             // 2t+1 (upper), 2t+3 (lower)
  localparam int unsigned NUM_W   = SP_W + KMAG_W;         // |numerator|
  localparam int unsigned BASE_W  = SP_W + BMUL_W;         // edge intercept
  localparam int unsigned DIVD_W  = NUM_W + FRAC_BITS;     // dividend, one stage per bit
  localparam int unsigned SLOPE_W = DIVD_W + 1;
  localparam int unsigned PROD_W  = SLOPE_W + XPOS_W + 1;
  localparam int unsigned H_W     = PROD_W + 1;

  localparam logic [ROW_W-1:0]    ROW_MAX   = '1;
  localparam logic [NS_W-1:0]     SENS_SAT  = NS_W'(MAX_SENSORS);
  localparam logic [PW_W-1:0]     WIDTH_SAT = PW_W'(MAX_WIDTH);
  localparam logic signed [H_W-1:0] ROUND_FX = H_W'(1) << FRAC_BITS;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUM_SENSORS     = 3'd0,
    CFG_PIXEL_WIDTH     = 3'd1,
    CFG_ELEMENT_SPACING = 3'd2,
    CFG_CANVAS_SIZE     = 3'd3,
    CFG_COLUMN_OFFSET   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [NS_W-1:0]   num_sensors;
    logic [PW_W-1:0]   pixel_width;
    logic [SP_W-1:0]   element_spacing;
    logic [CANV_W-1:0] canvas_size;
    logic [OFF_W-1:0]  column_offset;
  } cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0] source_mask;
    logic [IDX_W-1:0]  source_index;
    logic [IDX_W-1:0]  sensor_index;
    logic [GREY_W-1:0] intensity;
    logic [COL_W-1:0]  column;
  } in_t;

  typedef struct packed {
    logic [COL_W-1:0]  column_out;
    logic [ROW_W-1:0]  row_start;
    logic [ROW_W-1:0]  row_end;
    logic [GREY_W-1:0] grey_level;
  } out_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic [1:0][BASE_W-1:0] base;
    logic [XPOS_W-1:0]      xpos;
    logic [COL_W-1:0]       column;
    logic [GREY_W-1:0]      grey;
  } side_t;

  // Lane 0 is the upper edge, lane 1 the lower edge
  typedef struct packed {
    logic [1:0]             neg;
    logic [1:0][DIVD_W-1:0] mag;
    side_t                  side;
  } div_req_t;

  typedef struct packed {
    logic [1:0]             neg;
    logic [1:0]             rem_nz;
    logic [1:0][DIVD_W-1:0] quo;
    side_t                  side;
  } div_res_t;

endpackage

// ===== rtl/core/bcsg_prep.sv =====
module bcsg_prep (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  bcsg_pkg::in_t     data_i,
  input  bcsg_pkg::cfg_t    cfg_i,
  output logic              valid_o,
  output bcsg_pkg::div_req_t req_o
);
  import bcsg_pkg::*;

  logic [NS_W-1:0]         count;
  logic [PW_W-1:0]         width;
  logic                    pass;
  logic signed [IDX_W:0]   diff;
  logic signed [IDX_W+1:0] k_up;
  logic signed [IDX_W+1:0] k_lo;
  logic [KMAG_W-1:0]       kmag_up;
  logic [KMAG_W-1:0]       kmag_lo;
  logic [NUM_W-1:0]        num_up;
  logic [NUM_W-1:0]        num_lo;
  logic [BASE_W-1:0]       bmul_up;
  logic                    valid_q;
  div_req_t                req_d;
  div_req_t                req_q;

  // Request filter: saturated counts, enabled source, column in range
  always_comb begin
    count = (cfg_i.num_sensors > SENS_SAT) ? SENS_SAT : cfg_i.num_sensors;
    width = (cfg_i.pixel_width > WIDTH_SAT) ? WIDTH_SAT : cfg_i.pixel_width;
    pass  = ({1'b0, data_i.source_index} < count) &&
            ({1'b0, data_i.sensor_index} < count) &&
            data_i.source_mask[data_i.source_index] &&
            ({1'b0, data_i.column} < width);
  end

  // Slope numerators and edge intercepts, in half pixels
  always_comb begin
    diff    = $signed({1'b0, data_i.source_index}) - $signed({1'b0, data_i.sensor_index});
    k_up    = {diff, 1'b1};
    k_lo    = k_up - (IDX_W+2)'(2);
    kmag_up = KMAG_W'(k_up[IDX_W+1] ? -k_up : k_up);
    kmag_lo = KMAG_W'(k_lo[IDX_W+1] ? -k_lo : k_lo);
    num_up  = NUM_W'(cfg_i.element_spacing) * NUM_W'(kmag_up);
    num_lo  = NUM_W'(cfg_i.element_spacing) * NUM_W'(kmag_lo);
    bmul_up = BASE_W'({data_i.sensor_index, 1'b1});

    req_d.neg           = {k_lo[IDX_W+1], k_up[IDX_W+1]};
    req_d.mag[0]        = {num_up, {FRAC_BITS{1'b0}}};
    req_d.mag[1]        = {num_lo, {FRAC_BITS{1'b0}}};
    req_d.side.base[0]  = BASE_W'(cfg_i.element_spacing) * bmul_up;
    req_d.side.base[1]  = BASE_W'(cfg_i.element_spacing) * (bmul_up + BASE_W'(2));
    req_d.side.xpos     = XPOS_W'(data_i.column) + XPOS_W'(cfg_i.column_offset);
    req_d.side.column   = data_i.column;
    req_d.side.grey     = data_i.intensity;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i && pass;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/core/bcsg_div.sv =====
module bcsg_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  bcsg_pkg::div_req_t        req_i,
  input  logic [bcsg_pkg::CANV_W-1:0] den_i,
  output logic                      valid_o,
  output bcsg_pkg::div_res_t        res_o
);
  import bcsg_pkg::*;

  // One restoring step per stage, quotient bits shift in from the right
  logic [DIVD_W-1:0]            v_q;
  logic [1:0][CANV_W-1:0]       rem_d [DIVD_W];
  logic [1:0][CANV_W-1:0]       rem_q [DIVD_W];
  logic [1:0][DIVD_W-1:0]       dq_d  [DIVD_W];
  logic [1:0][DIVD_W-1:0]       dq_q  [DIVD_W];
  logic [1:0]                   neg_q [DIVD_W];
  side_t                        side_q [DIVD_W];

  always_comb begin
    logic [1:0][CANV_W-1:0] rem_p;
    logic [1:0][DIVD_W-1:0] dq_p;
    logic [CANV_W:0]        trial;
    logic                   ge;
    for (int g = 0; g < DIVD_W; g++) begin
      if (g == 0) begin
        rem_p = '0;
        dq_p  = req_i.mag;
      end else begin
        rem_p = rem_q[g-1];
        dq_p  = dq_q[g-1];
      end
      for (int l = 0; l < 2; l++) begin
        trial          = {rem_p[l], dq_p[l][DIVD_W-1]};
        ge             = trial >= {1'b0, den_i};
        rem_d[g][l]    = ge ? CANV_W'(trial - {1'b0, den_i}) : trial[CANV_W-1:0];
        dq_d[g][l]     = {dq_p[l][DIVD_W-2:0], ge};
      end
    end
  end

  // Valid bits travel with the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIVD_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < DIVD_W; g++) begin
        rem_q[g] <= rem_d[g];
        dq_q[g]  <= dq_d[g];
        if (g == 0) begin
          neg_q[g]  <= req_i.neg;
          side_q[g] <= req_i.side;
        end else begin
          neg_q[g]  <= neg_q[g-1];
          side_q[g] <= side_q[g-1];
        end
      end
    end
  end

  always_comb begin
    res_o.neg       = neg_q[DIVD_W-1];
    res_o.quo       = dq_q[DIVD_W-1];
    res_o.rem_nz[0] = |rem_q[DIVD_W-1][0];
    res_o.rem_nz[1] = |rem_q[DIVD_W-1][1];
    res_o.side      = side_q[DIVD_W-1];
  end

  assign valid_o = v_q[DIVD_W-1];

endmodule

// ===== rtl/core/bcsg_edge.sv =====
module bcsg_edge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  bcsg_pkg::div_res_t res_i,
  output logic               valid_o,
  output bcsg_pkg::out_t     span_o
);
  import bcsg_pkg::*;

  logic [2:0]                v_q;
  logic signed [SLOPE_W-1:0] slope_d [2];
  logic signed [SLOPE_W-1:0] slope_q [2];
  side_t                     side1_q;
  logic signed [PROD_W-1:0]  prod_d [2];
  logic signed [PROD_W-1:0]  prod_q [2];
  side_t                     side2_q;
  logic [ROW_W-1:0]          row_d [2];
  out_t                      span_q;

  // Stage 1: signed slope, floored toward minus infinity
  always_comb begin
    logic [SLOPE_W-1:0] q_ext;
    logic [SLOPE_W-1:0] q_up;
    for (int l = 0; l < 2; l++) begin
      q_ext      = {1'b0, res_i.quo[l]};
      q_up       = q_ext + SLOPE_W'(res_i.rem_nz[l]);
      slope_d[l] = res_i.neg[l] ? $signed(-q_up) : $signed(q_ext);
    end
  end

  // Stage 2: slope times horizontal position
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      prod_d[l] = PROD_W'(slope_q[l]) * $signed({1'b0, side1_q.xpos});
    end
  end

  // Stage 3: add intercept, round half up to rows, clamp
  always_comb begin
    logic signed [H_W-1:0] h;
    logic signed [H_W-1:0] y_full;
    for (int l = 0; l < 2; l++) begin
      h = H_W'(prod_q[l]) +
          $signed({{(H_W-BASE_W-FRAC_BITS){1'b0}}, side2_q.base[l], {FRAC_BITS{1'b0}}}) +
          ROUND_FX;
      y_full = h >>> (FRAC_BITS + 1);
      if (y_full[H_W-1]) begin
        row_d[l] = '0;
      end else if (|y_full[H_W-2:ROW_W]) begin
        row_d[l] = ROW_MAX;
      end else begin
        row_d[l] = y_full[ROW_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      slope_q           <= slope_d;
      side1_q           <= res_i.side;
      prod_q            <= prod_d;
      side2_q           <= side1_q;
      span_q.column_out <= side2_q.column;
      span_q.row_start  <= row_d[0];
      span_q.row_end    <= row_d[1];
      span_q.grey_level <= side2_q.grey;
    end
  end

  assign valid_o = v_q[2];
  assign span_o  = span_q;

endmodule

// ===== rtl/core/beam_column_span_generator_top.sv =====
// Pipeline: a filter stage, one divider stage per dividend bit, the edge stages and an output register.
// Throughput: one request per cycle while in_stall_o is low; the slope divider retires one quotient bit per stage.
// A stalled result parks in a one-entry skid register; in_stall_o rises only when it is full.
// Reset is asynchronous, active low: clears all valid bits and loads register defaults.
module beam_column_span_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  bcsg_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output bcsg_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bcsg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bcsg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bcsg_pkg::*;

  cfg_t              cfg_q;
  logic [CANV_W-1:0] den;
  logic              en;
  logic              prep_valid;
  div_req_t          prep_req;
  logic              div_valid;
  div_res_t          div_res;
  logic              edge_valid;
  out_t              edge_span;
  logic              new_valid;
  logic              out_take;
  logic              out_v_d, out_v_q;
  out_t              out_d, out_q;
  logic              skid_v_d, skid_v_q;
  out_t              skid_d, skid_q;

  // Register file
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_sensors     <= NS_W'(16);
      cfg_q.pixel_width     <= PW_W'(256);
      cfg_q.element_spacing <= SP_W'(15);
      cfg_q.canvas_size     <= CANV_W'(512);
      cfg_q.column_offset   <= OFF_W'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NUM_SENSORS:     cfg_q.num_sensors     <= cfg_data_i[NS_W-1:0];
        CFG_PIXEL_WIDTH:     cfg_q.pixel_width     <= cfg_data_i[PW_W-1:0];
        CFG_ELEMENT_SPACING: cfg_q.element_spacing <= cfg_data_i[SP_W-1:0];
        CFG_CANVAS_SIZE:     cfg_q.canvas_size     <= cfg_data_i[CANV_W-1:0];
        CFG_COLUMN_OFFSET:   cfg_q.column_offset   <= cfg_data_i[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero canvas divides as one
  assign den = (cfg_q.canvas_size == '0) ? CANV_W'(1) : cfg_q.canvas_size;

  // Whole pipeline moves unless the skid register is holding a result
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  bcsg_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cfg_i   (cfg_q),
    .valid_o (prep_valid),
    .req_o   (prep_req)
  );

  bcsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .req_i   (prep_req),
    .den_i   (den),
    .valid_o (div_valid),
    .res_o   (div_res)
  );

  bcsg_edge u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .res_i   (div_res),
    .valid_o (edge_valid),
    .span_o  (edge_span)
  );

  // Empty spans are dropped here
  assign new_valid = edge_valid && (edge_span.row_start < edge_span.row_end);
  assign out_take  = out_v_q && !out_stall_i;

  // Output register with one-entry skid
  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      if (!out_v_q || out_take) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else begin
      if (out_take) begin
        out_v_d = 1'b0;
      end
      if (new_valid) begin
        if (!out_v_q || out_take) begin
          out_v_d = 1'b1;
          out_d   = edge_span;
        end else begin
          skid_v_d = 1'b1;
          skid_d   = edge_span;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // The skid entry is only ever used behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid register full with empty output register");

  // Every delivered span is non-empty
  a_span_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> (out_q.row_start < out_q.row_end))
    else $error("empty span presented at output");

  // The skid only fills when the output was stalled
  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q && skid_v_d |-> out_v_q && out_stall_i)
    else $error("skid filled without an output stall");

  // A held skid entry stays while the output is stalled
  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q && $stable(skid_q))
    else $error("skid entry lost during output stall");

endmodule
